/* rtl/sall_pkg.sv */
// ----------------------------------------------------------------------------
// sall_pkg
// Shared types and constants for the sorted array linked list core.
// ----------------------------------------------------------------------------
package sall_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    req_t                       req_type;
    logic signed [VALUE_W-1:0]  value;
  } sall_in_t;

  typedef struct packed {
    status_t                    status;
    logic        [SLOT_W-1:0]   slot;
  } sall_out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_HEAD,
    S_LINK0,
    S_STEP,
    S_WR1,
    S_WR2,
    S_DW1,
    S_DW2,
    S_RESP
  } state_t;

endpackage

/* rtl/sall_ram.sv */
// ----------------------------------------------------------------------------
// sall_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sall_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sorted_array_linked_list_core.sv */
// ----------------------------------------------------------------------------
// sorted_array_linked_list_core
// Ascending list of signed 32-bit values kept as links in a slot array.
// ----------------------------------------------------------------------------
// Usage:
//   in_data (req_type, value) is taken on in_valid & in_ready. An insert puts
//   the value into the lowest free slot and links it after the last element
//   not greater than it; a delete unlinks the first equal element and frees
//   its slot. Every word on the input yields exactly one word on out_data
//   (status, slot), handed over on out_valid & out_ready.
//   One item is worked at a time. An insert runs the free-slot scan (one
//   flag per cycle, over slots 1 to SLOTS-1) and then the list walk (one
//   element per cycle through the link and value RAMs); a delete runs only
//   the walk.
//   The walk pace is set by the registered read data of the RAMs: each
//   element's link read drives the next element's address.
//   After reset a clearing pass writes zero to every link entry, with
//   in_ready low. If the receiver stalls, the finished result waits in the
//   output register; the core still takes and works the next word and
//   holds its result until the output register frees up.
// ----------------------------------------------------------------------------
module sorted_array_linked_list_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sall_pkg::sall_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sall_pkg::sall_out_t out_data
);
  import sall_pkg::*;

  localparam idx_t LAST = IDX_W'(SLOTS - 1);

  // Control state
  state_t     state_r, state_nxt;
  idx_t       scan_r, scan_nxt;
  logic [SLOTS-1:0] free_r, free_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Working registers
  idx_t       cell_r, cell_nxt;
  idx_t       prev_r, prev_nxt;
  idx_t       cur_r, cur_nxt;
  idx_t       next_r, next_nxt;
  req_t       req_r, req_nxt;
  logic signed [VALUE_W-1:0] x_r, x_nxt;
  sall_out_t  res_r, res_nxt;
  sall_out_t  out_data_r, out_data_nxt;

  // RAM ports
  logic       link_we, val_we;
  idx_t       link_waddr, link_wdata, link_raddr, link_rdata;
  idx_t       val_waddr, val_raddr;
  logic [VALUE_W-1:0] val_wdata, val_rdata;

  sall_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  sall_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scan_r      <= '0;
      free_r      <= {{(SLOTS-1){1'b1}}, 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r     <= cell_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    next_r     <= next_nxt;
    req_r      <= req_nxt;
    x_r        <= x_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r;
    cell_nxt      = cell_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    req_nxt       = req_r;
    x_nxt         = x_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;

    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_raddr = '0;
    val_we     = 1'b0;
    val_waddr  = '0;
    val_wdata  = '0;
    val_raddr  = '0;

    // Drain the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        // Zero one link entry per cycle; the sentinel ends up pointing to itself
        link_we    = 1'b1;
        link_waddr = scan_r;
        if (scan_r == LAST) begin
          scan_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          scan_nxt = scan_r + idx_t'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data.req_type;
          x_nxt   = in_data.value;
          if (in_data.req_type == REQ_INSERT) begin
            scan_nxt  = idx_t'(1);
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_HEAD;
          end
        end
      end

      S_SCAN: begin
        // Look for the lowest free slot, one flag per cycle
        if (free_r[scan_r]) begin
          cell_nxt  = scan_r;
          state_nxt = S_HEAD;
        end else if (scan_r == LAST) begin
          res_nxt.status = ST_FULL;
          res_nxt.slot   = '0;
          state_nxt      = S_RESP;
        end else begin
          scan_nxt = scan_r + idx_t'(1);
        end
      end

      S_HEAD: begin
        link_raddr = '0;
        prev_nxt   = '0;
        state_nxt  = S_LINK0;
      end

      S_LINK0: begin
        // First element after the sentinel
        if (link_rdata == '0) begin
          if (req_r == REQ_INSERT) begin
            next_nxt  = '0;
            state_nxt = S_WR1;
          end else begin
            res_nxt.status = ST_NOT_FOUND;
            res_nxt.slot   = '0;
            state_nxt      = S_RESP;
          end
        end else begin
          cur_nxt    = link_rdata;
          link_raddr = link_rdata;
          val_raddr  = link_rdata;
          state_nxt  = S_STEP;
        end
      end

      S_STEP: begin
        // Value and link of cur_r are on the RAM outputs
        if (req_r == REQ_INSERT) begin
          if ($signed(val_rdata) > x_r) begin
            next_nxt  = cur_r;
            state_nxt = S_WR1;
          end else begin
            prev_nxt = cur_r;
            if (link_rdata == '0) begin
              next_nxt  = '0;
              state_nxt = S_WR1;
            end else begin
              cur_nxt    = link_rdata;
              link_raddr = link_rdata;
              val_raddr  = link_rdata;
            end
          end
        end else begin
          if ($signed(val_rdata) == x_r) begin
            next_nxt  = link_rdata;
            state_nxt = S_DW1;
          end else begin
            prev_nxt = cur_r;
            if (link_rdata == '0) begin
              res_nxt.status = ST_NOT_FOUND;
              res_nxt.slot   = '0;
              state_nxt      = S_RESP;
            end else begin
              cur_nxt    = link_rdata;
              link_raddr = link_rdata;
              val_raddr  = link_rdata;
            end
          end
        end
      end

      S_WR1: begin
        // New element points to its successor and takes the value
        link_we    = 1'b1;
        link_waddr = cell_r;
        link_wdata = next_r;
        val_we     = 1'b1;
        val_waddr  = cell_r;
        val_wdata  = x_r;
        state_nxt  = S_WR2;
      end

      S_WR2: begin
        link_we          = 1'b1;
        link_waddr       = prev_r;
        link_wdata       = cell_r;
        free_nxt[cell_r] = 1'b0;
        res_nxt.status   = ST_OK;
        res_nxt.slot     = SLOT_W'(cell_r);
        state_nxt        = S_RESP;
      end

      S_DW1: begin
        // Bypass the found element
        link_we    = 1'b1;
        link_waddr = prev_r;
        link_wdata = next_r;
        state_nxt  = S_DW2;
      end

      S_DW2: begin
        link_we         = 1'b1;
        link_waddr      = cur_r;
        link_wdata      = '0;
        free_nxt[cur_r] = 1'b1;
        res_nxt.status  = ST_OK;
        res_nxt.slot    = SLOT_W'(cur_r);
        state_nxt       = S_RESP;
      end

      S_RESP: begin
        // Hold until the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
